>>> design/lsc_pkg.sv
// ---------------------------------------------------------------------------
// lsc_pkg: shared types and constants for the line sensor centroid unit
// Calibration tables, fixed-point widths, pipeline stage indexes and the
// packed words that travel between the lanes, the merge and the divider.
// ---------------------------------------------------------------------------
package lsc_pkg;

  // Sensor bar size; the input word carries exactly this many readings
  localparam int SENSOR_COUNT = 8;

  // Field and intermediate widths (units of 2^-16)
  localparam int RAW_W  = 8;                // raw sensor byte
  localparam int OFS_W  = 20;               // signed calibration offset
  localparam int GAIN_W = 13;               // unsigned calibration gain
  localparam int SPOS_W = 14;               // signed sensor position
  localparam int VAL_W  = 22;               // signed calibrated value
  localparam int WGT_W  = 21;               // unsigned weight, max - value
  localparam int PROD_W = 34;               // signed position * weight
  localparam int NUM_W  = 37;               // signed weighted position sum
  localparam int DEN_W  = 24;               // unsigned weight sum
  localparam int Q_W    = 13;               // quotient magnitude
  localparam int DVD_W  = DEN_W + Q_W;      // rounded dividend magnitude
  localparam int LPOS_W = Q_W + 1;          // signed line position

  // Pipeline stages ahead of the output register
  localparam int ST_CAL   = 0;              // per-lane calibration
  localparam int ST_MAX   = 1;              // maximum over lanes
  localparam int ST_WGT   = 2;              // per-lane weight and product
  localparam int ST_HALF  = 3;              // half-bar partial sums
  localparam int ST_SUM   = 4;              // full sums
  localparam int ST_PREP  = 5;              // magnitude plus half divisor
  localparam int ST_DIV0  = 6;              // first divider stage
  localparam int STAGES   = ST_DIV0 + Q_W;

  // Calibration tables, one entry per sensor, leftmost first
  localparam logic signed [OFS_W-1:0] CAL_OFFSET [SENSOR_COUNT] = '{
    -20'sd356693, -20'sd314173, -20'sd205514, -20'sd329882,
    -20'sd342583, -20'sd344300, -20'sd304454, -20'sd117834
  };
  localparam logic [GAIN_W-1:0] CAL_GAIN [SENSOR_COUNT] = '{
    13'd7189, 13'd6284, 13'd4101, 13'd6633,
    13'd6925, 13'd6921, 13'd6140, 13'd2241
  };
  localparam logic signed [SPOS_W-1:0] SENSOR_POS [SENSOR_COUNT] = '{
    14'sd4129, 14'sd2949, 14'sd1769, 14'sd590,
    -14'sd590, -14'sd1769, -14'sd2949, -14'sd4129
  };

  // Input word: one reading of the whole bar
  typedef struct packed {
    logic [RAW_W-1:0] sensor_0;
    logic [RAW_W-1:0] sensor_1;
    logic [RAW_W-1:0] sensor_2;
    logic [RAW_W-1:0] sensor_3;
    logic [RAW_W-1:0] sensor_4;
    logic [RAW_W-1:0] sensor_5;
    logic [RAW_W-1:0] sensor_6;
    logic [RAW_W-1:0] sensor_7;
  } lsc_in_t;

  // Result word
  typedef struct packed {
    logic signed [LPOS_W-1:0] line_position;
    logic                     flat_reading;
  } lsc_out_t;

  // Per-stage advance enables
  typedef logic [STAGES-1:0] lsc_adv_t;

  // Per-lane calibration constants
  typedef struct packed {
    logic signed [OFS_W-1:0]  offset;
    logic [GAIN_W-1:0]        gain;
    logic signed [SPOS_W-1:0] spos;
  } lsc_cal_t;

  // Divider operands
  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             flat;
  } lsc_div_t;

  // Divider result
  typedef struct packed {
    logic [Q_W-1:0] quo;
    logic           neg;
    logic           flat;
  } lsc_quo_t;

endpackage

>>> design/line_sensor_centroid_unit.sv
// ---------------------------------------------------------------------------
// line_sensor_centroid_unit: line position from an eight-sensor bar
// Calibrates each sensor in its own lane, weights each by (max - value),
// and divides the weighted position sum by the weight sum.
//
//   channel | ports                          | word
//   --------+--------------------------------+-----------------------------
//   input   | in_valid, in_stall, in_word    | eight raw sensor bytes
//   output  | out_valid, out_stall, out_word | line_position, flat_reading
//
// Takes one word per cycle while in_stall is low, through 6 lane and merge
// stages, 13 divider stages (one quotient bit each) and the output register.
// Reset clears all stage valid bits and the output valid; data registers
// are not reset. Each stage advances when it or any later stage is empty,
// so bubbles collapse while out_stall is high; in_stall rises only when
// every stage and the output register hold a word and out_stall is high.
// ---------------------------------------------------------------------------
module line_sensor_centroid_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lsc_pkg::lsc_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output lsc_pkg::lsc_out_t out_word
);
  import lsc_pkg::*;

  logic [STAGES-1:0]       v_r;
  logic [STAGES-1:0]       v_nxt;
  lsc_adv_t                adv;
  logic                    out_adv;
  logic                    out_valid_r;
  lsc_out_t                out_word_r;
  lsc_out_t                out_word_nxt;

  lsc_cal_t                lane_cal  [SENSOR_COUNT];
  logic [RAW_W-1:0]        raw       [SENSOR_COUNT];
  logic signed [VAL_W-1:0] lane_val  [SENSOR_COUNT];
  logic [WGT_W-1:0]        lane_wgt  [SENSOR_COUNT];
  logic signed [PROD_W-1:0] lane_prod [SENSOR_COUNT];
  logic signed [VAL_W-1:0] hi;
  lsc_div_t                div_w;
  lsc_quo_t                quo_w;

  // Raw bytes, leftmost sensor first
  assign raw[0] = in_word.sensor_0;
  assign raw[1] = in_word.sensor_1;
  assign raw[2] = in_word.sensor_2;
  assign raw[3] = in_word.sensor_3;
  assign raw[4] = in_word.sensor_4;
  assign raw[5] = in_word.sensor_5;
  assign raw[6] = in_word.sensor_6;
  assign raw[7] = in_word.sensor_7;

  // Flow control: a stage moves when an empty slot exists at or after it
  assign out_adv = !out_valid_r || !out_stall;

  for (genvar k = 0; k < STAGES; k++) begin : g_adv
    assign adv[k] = out_adv || !(&v_r[STAGES-1:k]);
  end

  assign in_stall = !adv[0];

  always_comb begin
    v_nxt = v_r;
    if (adv[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (adv[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Sensor lanes
  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
    assign lane_cal[i].offset = CAL_OFFSET[i];
    assign lane_cal[i].gain   = CAL_GAIN[i];
    assign lane_cal[i].spos   = SENSOR_POS[i];

    lsc_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .cal  (lane_cal[i]),
      .raw  (raw[i]),
      .hi   (hi),
      .val  (lane_val[i]),
      .wgt  (lane_wgt[i]),
      .prod (lane_prod[i])
    );
  end

  // Merge and divide
  lsc_merge u_merge (
    .clk      (clk),
    .adv      (adv),
    .val      (lane_val),
    .wgt      (lane_wgt),
    .prod     (lane_prod),
    .hi       (hi),
    .div_word (div_w)
  );

  lsc_div u_div (
    .clk      (clk),
    .adv      (adv),
    .div_word (div_w),
    .quo_word (quo_w)
  );

  // Sign and flat override
  always_comb begin
    out_word_nxt.flat_reading = quo_w.flat;
    if (quo_w.flat) begin
      out_word_nxt.line_position = '0;
    end else if (quo_w.neg) begin
      out_word_nxt.line_position = -signed'({1'b0, quo_w.quo});
    end else begin
      out_word_nxt.line_position = signed'({1'b0, quo_w.quo});
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= v_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && v_r[STAGES-1]) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef ASSERT_OFF
  // A flat reading always reports the center position
  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.flat_reading |-> out_word_r.line_position == '0)
    else $error("flat reading with nonzero position");

  // Input stalls only with every stage full and the output blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r) && out_valid_r && out_stall)
    else $error("input stalled with a free pipeline slot");

  // Position stays within the outer sensor positions
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.line_position >= -14'sd4129)
                 && (out_word_r.line_position <= 14'sd4129))
    else $error("line position out of range");

  // Divider operands keep the quotient within Q_W bits
  a_div_fit: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_PREP] && !div_w.flat |-> div_w.dvd[DVD_W-1:Q_W] < div_w.den)
    else $error("divider dividend too large for quotient width");

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("output valid right after reset");
`endif

endmodule

>>> design/lsc_lane.sv
// ---------------------------------------------------------------------------
// lsc_lane: one sensor lane
// Calibrates one raw byte, then forms its weight against the bar maximum
// and the product of weight and sensor position.
// ---------------------------------------------------------------------------
module lsc_lane (
  input  logic                                 clk,
  input  lsc_pkg::lsc_adv_t                    adv,
  input  lsc_pkg::lsc_cal_t                    cal,
  input  logic [lsc_pkg::RAW_W-1:0]            raw,
  input  logic signed [lsc_pkg::VAL_W-1:0]     hi,
  output logic signed [lsc_pkg::VAL_W-1:0]     val,
  output logic [lsc_pkg::WGT_W-1:0]            wgt,
  output logic signed [lsc_pkg::PROD_W-1:0]    prod
);
  import lsc_pkg::*;

  logic [GAIN_W+RAW_W-1:0]  gr;
  logic signed [VAL_W-1:0]  val_nxt;
  logic signed [VAL_W-1:0]  val_r;
  logic signed [VAL_W-1:0]  val_d_r;
  logic [WGT_W-1:0]         wgt_nxt;
  logic [WGT_W-1:0]         wgt_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;

  // Calibration: offset + gain * raw
  assign gr      = cal.gain * raw;
  assign val_nxt = VAL_W'(cal.offset) + VAL_W'(gr);

  always_ff @(posedge clk) begin
    if (adv[ST_CAL]) begin
      val_r <= val_nxt;
    end
  end

  // Hold the value while the merge finds the maximum
  always_ff @(posedge clk) begin
    if (adv[ST_MAX]) begin
      val_d_r <= val_r;
    end
  end

  // Weight is never negative and fits WGT_W bits
  assign wgt_nxt  = WGT_W'(hi - val_d_r);
  assign prod_nxt = PROD_W'(cal.spos) * PROD_W'(signed'({1'b0, wgt_nxt}));

  always_ff @(posedge clk) begin
    if (adv[ST_WGT]) begin
      wgt_r  <= wgt_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign val  = val_r;
  assign wgt  = wgt_r;
  assign prod = prod_r;

endmodule

>>> design/lsc_merge.sv
// ---------------------------------------------------------------------------
// lsc_merge: combines the lanes
// Finds the bar maximum, sums weights and weighted positions over two
// stages, and prepares the rounded dividend magnitude for the divider.
// ---------------------------------------------------------------------------
module lsc_merge (
  input  logic                                 clk,
  input  lsc_pkg::lsc_adv_t                    adv,
  input  logic signed [lsc_pkg::VAL_W-1:0]     val  [lsc_pkg::SENSOR_COUNT],
  input  logic [lsc_pkg::WGT_W-1:0]            wgt  [lsc_pkg::SENSOR_COUNT],
  input  logic signed [lsc_pkg::PROD_W-1:0]    prod [lsc_pkg::SENSOR_COUNT],
  output logic signed [lsc_pkg::VAL_W-1:0]     hi,
  output lsc_pkg::lsc_div_t                    div_word
);
  import lsc_pkg::*;

  localparam int HALF = SENSOR_COUNT / 2;

  logic signed [VAL_W-1:0] hi_nxt;
  logic signed [VAL_W-1:0] hi_r;
  logic signed [NUM_W-1:0] num_lo_nxt, num_hi_nxt;
  logic signed [NUM_W-1:0] num_lo_r, num_hi_r;
  logic [DEN_W-1:0]        den_lo_nxt, den_hi_nxt;
  logic [DEN_W-1:0]        den_lo_r, den_hi_r;
  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]        den_r;
  logic                    neg;
  lsc_div_t                div_nxt;
  lsc_div_t                div_r;

  // Bar maximum
  always_comb begin
    hi_nxt = val[0];
    for (int i = 1; i < SENSOR_COUNT; i++) begin
      if (val[i] > hi_nxt) begin
        hi_nxt = val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_MAX]) begin
      hi_r <= hi_nxt;
    end
  end

  // Partial sums over each half of the bar
  always_comb begin
    num_lo_nxt = '0;
    num_hi_nxt = '0;
    den_lo_nxt = '0;
    den_hi_nxt = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (i < HALF) begin
        num_lo_nxt = num_lo_nxt + NUM_W'(prod[i]);
        den_lo_nxt = den_lo_nxt + DEN_W'(wgt[i]);
      end else begin
        num_hi_nxt = num_hi_nxt + NUM_W'(prod[i]);
        den_hi_nxt = den_hi_nxt + DEN_W'(wgt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_HALF]) begin
      num_lo_r <= num_lo_nxt;
      num_hi_r <= num_hi_nxt;
      den_lo_r <= den_lo_nxt;
      den_hi_r <= den_hi_nxt;
    end
  end

  // Full sums
  always_ff @(posedge clk) begin
    if (adv[ST_SUM]) begin
      num_r <= num_lo_r + num_hi_r;
      den_r <= den_lo_r + den_hi_r;
    end
  end

  // |num| + den/2, with the negation folded into one three-input add
  assign neg = num_r[NUM_W-1];

  always_comb begin
    div_nxt.dvd  = DVD_W'(neg ? ~num_r : num_r) + DVD_W'(den_r >> 1) + DVD_W'(neg);
    div_nxt.den  = den_r;
    div_nxt.neg  = neg;
    div_nxt.flat = (den_r == '0);
  end

  always_ff @(posedge clk) begin
    if (adv[ST_PREP]) begin
      div_r <= div_nxt;
    end
  end

  assign hi       = hi_r;
  assign div_word = div_r;

endmodule

>>> design/lsc_div.sv
// ---------------------------------------------------------------------------
// lsc_div: pipelined restoring divider
// One quotient bit per stage, Q_W stages. The dividend is known to be
// below den * 2^Q_W, so the quotient fits Q_W bits.
// ---------------------------------------------------------------------------
module lsc_div (
  input  logic               clk,
  input  lsc_pkg::lsc_adv_t  adv,
  input  lsc_pkg::lsc_div_t  div_word,
  output lsc_pkg::lsc_quo_t  quo_word
);
  import lsc_pkg::*;

  logic [DEN_W-1:0] rem_r  [Q_W];
  logic [Q_W-1:0]   low_r  [Q_W];
  logic [DEN_W-1:0] den_r  [Q_W];
  logic             neg_r  [Q_W];
  logic             flat_r [Q_W];

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  // The low word shifts dividend bits out and quotient bits in.
  function automatic logic [DEN_W+Q_W-1:0] div_step(
    input logic [DEN_W-1:0] rem,
    input logic [Q_W-1:0]   low,
    input logic [DEN_W-1:0] den
  );
    logic [DEN_W:0] t;
    logic           b;
    t = {rem, low[Q_W-1]};
    b = (t >= {1'b0, den});
    if (b) begin
      t = t - {1'b0, den};
    end
    return {t[DEN_W-1:0], low[Q_W-2:0], b};
  endfunction

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [Q_W-1:0]   low_in;
    logic [DEN_W-1:0] den_in;
    logic             neg_in;
    logic             flat_in;

    if (k == 0) begin : g_first
      assign rem_in  = div_word.dvd[DVD_W-1:Q_W];
      assign low_in  = div_word.dvd[Q_W-1:0];
      assign den_in  = div_word.den;
      assign neg_in  = div_word.neg;
      assign flat_in = div_word.flat;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign low_in  = low_r[k-1];
      assign den_in  = den_r[k-1];
      assign neg_in  = neg_r[k-1];
      assign flat_in = flat_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv[ST_DIV0+k]) begin
        {rem_r[k], low_r[k]} <= div_step(rem_in, low_in, den_in);
        den_r[k]             <= den_in;
        neg_r[k]             <= neg_in;
        flat_r[k]            <= flat_in;
      end
    end
  end

  assign quo_word.quo  = low_r[Q_W-1];
  assign quo_word.neg  = neg_r[Q_W-1];
  assign quo_word.flat = flat_r[Q_W-1];

endmodule
